// ===== rtl/shrp_pkg.sv =====
package shrp_pkg;

  localparam int unsigned MAX_NAMES  = 16;
  localparam int unsigned NAME_W     = 32;
  localparam int unsigned DEPTH_W    = 32;
  localparam int unsigned HIT_W      = 16;
  // name store address and fill count
  localparam int unsigned IDX_W      = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_NAMES + 1);
  // output queue, power of two so the pointers wrap by themselves
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);
  // config port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  // stream packing
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    KIND_ALL  = 2'd0,
    KIND_NEAR = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    POS_COUNT = 4'b0001,
    POS_MIN   = 4'b0010,
    POS_MAX   = 4'b0100,
    POS_NAMES = 4'b1000
  } pos_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_COUNT = 1'b0,
    REG_MODE      = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [NAME_W-1:0]  name_value;
    logic [DEPTH_W-1:0] depth;
    logic               truncated;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   count;
    logic [DEPTH_W-1:0] depth;
    logic               truncated;
  } burst_start_t;

  typedef struct packed {
    logic                  valid;
    reg_e                  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/shrp_name_ram.sv =====
module shrp_name_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/shrp_parser.sv =====
module shrp_parser (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  shrp_pkg::cfg_wr_t                      cfg_i,
  input  logic                                   accept_i,
  input  logic                                   cmd_i,
  input  logic [shrp_pkg::NAME_W-1:0]            word_i,
  output logic                                   push_o,
  output shrp_pkg::res_t                         push_res_o,
  output shrp_pkg::burst_start_t                 burst_o,
  output logic                                   ram_we_o,
  output logic [shrp_pkg::IDX_W-1:0]             ram_waddr_o,
  output logic [shrp_pkg::NAME_W-1:0]            ram_wdata_o
);

  logic [shrp_pkg::HIT_W-1:0]   hit_count_q;
  logic                         mode_q;

  shrp_pkg::pos_e               pos_q, pos_d;
  logic [shrp_pkg::NAME_W-1:0]  names_left_q, names_left_d;
  logic [shrp_pkg::HIT_W-1:0]   records_q, records_d;
  logic [shrp_pkg::DEPTH_W-1:0] cur_depth_q, cur_depth_d;
  logic                         capture_q, capture_d;
  logic [shrp_pkg::DEPTH_W-1:0] best_depth_q, best_depth_d;
  logic [shrp_pkg::CNT_W-1:0]   best_count_q, best_count_d;
  logic                         best_trunc_q, best_trunc_d;

  // config registers; the user must write them only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_count_q <= '0;
      mode_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        shrp_pkg::REG_HIT_COUNT: hit_count_q <= cfg_i.data[shrp_pkg::HIT_W-1:0];
        shrp_pkg::REG_MODE:      mode_q      <= cfg_i.data[0];
        default:                 mode_q      <= mode_q;
      endcase
    end
  end

  always_comb begin
    pos_d        = pos_q;
    names_left_d = names_left_q;
    records_d    = records_q;
    cur_depth_d  = cur_depth_q;
    capture_d    = capture_q;
    best_depth_d = best_depth_q;
    best_count_d = best_count_q;
    best_trunc_d = best_trunc_q;

    push_o                = 1'b0;
    push_res_o.kind       = shrp_pkg::KIND_ALL;
    push_res_o.name_value = word_i;
    push_res_o.depth      = cur_depth_q;
    push_res_o.truncated  = 1'b0;
    push_res_o.last       = 1'b0;

    burst_o.valid     = 1'b0;
    burst_o.count     = best_count_q;
    burst_o.depth     = best_depth_q;
    burst_o.truncated = best_trunc_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = best_count_q[shrp_pkg::IDX_W-1:0];
    ram_wdata_o = word_i;

    if (accept_i) begin
      if (cmd_i) begin
        if (mode_q) begin
          // a nonzero fill count implies a best record was found
          if (best_count_q != '0) begin
            burst_o.valid = 1'b1;
          end else begin
            push_o                = 1'b1;
            push_res_o.kind       = shrp_pkg::KIND_NONE;
            push_res_o.name_value = '0;
            push_res_o.depth      = '0;
            push_res_o.last       = 1'b1;
          end
        end
        pos_d        = shrp_pkg::POS_COUNT;
        names_left_d = '0;
        records_d    = '0;
        cur_depth_d  = '0;
        capture_d    = 1'b0;
        best_depth_d = '1;
        best_count_d = '0;
        best_trunc_d = 1'b0;
      end else if (records_q < hit_count_q) begin
        unique case (pos_q)
          shrp_pkg::POS_COUNT: begin
            names_left_d = word_i;
            pos_d        = shrp_pkg::POS_MIN;
          end
          shrp_pkg::POS_MIN: begin
            cur_depth_d = word_i;
            capture_d   = 1'b0;
            if (mode_q && (names_left_q != '0) && (word_i < best_depth_q)) begin
              best_depth_d = word_i;
              best_count_d = '0;
              best_trunc_d = 1'b0;
              capture_d    = 1'b1;
            end
            pos_d = shrp_pkg::POS_MAX;
          end
          shrp_pkg::POS_MAX: begin
            if (names_left_q == '0) begin
              records_d = records_q + 1'b1;
              pos_d     = shrp_pkg::POS_COUNT;
              capture_d = 1'b0;
            end else begin
              pos_d = shrp_pkg::POS_NAMES;
            end
          end
          shrp_pkg::POS_NAMES: begin
            if (!mode_q) begin
              push_o = 1'b1;
            end else if (capture_q) begin
              if (best_count_q < shrp_pkg::CNT_W'(shrp_pkg::MAX_NAMES)) begin
                ram_we_o     = 1'b1;
                best_count_d = best_count_q + 1'b1;
              end else begin
                best_trunc_d = 1'b1;
              end
            end
            names_left_d = names_left_q - 1'b1;
            if (names_left_q == shrp_pkg::NAME_W'(1)) begin
              records_d = records_q + 1'b1;
              pos_d     = shrp_pkg::POS_COUNT;
              capture_d = 1'b0;
            end
          end
          default: pos_d = shrp_pkg::POS_COUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= shrp_pkg::POS_COUNT;
      names_left_q <= '0;
      records_q    <= '0;
      cur_depth_q  <= '0;
      capture_q    <= 1'b0;
      best_depth_q <= '1;
      best_count_q <= '0;
      best_trunc_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      names_left_q <= names_left_d;
      records_q    <= records_d;
      cur_depth_q  <= cur_depth_d;
      capture_q    <= capture_d;
      best_depth_q <= best_depth_d;
      best_count_q <= best_count_d;
      best_trunc_q <= best_trunc_d;
    end
  end

endmodule

// ===== rtl/shrp_burst.sv =====
module shrp_burst (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  shrp_pkg::burst_start_t        start_i,
  input  logic [shrp_pkg::FCNT_W-1:0]   fifo_count_i,
  output logic                          busy_o,
  output logic                          ram_re_o,
  output logic [shrp_pkg::IDX_W-1:0]    ram_raddr_o,
  input  logic [shrp_pkg::NAME_W-1:0]   ram_rdata_i,
  output logic                          push_o,
  output shrp_pkg::res_t                push_res_o
);

  localparam int unsigned SUM_W = shrp_pkg::FCNT_W + 1;

  logic                         active_q, active_d;
  logic [shrp_pkg::CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic [shrp_pkg::CNT_W-1:0]   total_q, total_d;
  logic [shrp_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic                         trunc_q, trunc_d;
  logic                         inflight_q, inflight_d;
  logic                         last_q, last_d;
  logic                         issue;
  logic                         is_last;

  // reserve queue room for the read already in flight
  assign issue = active_q &&
                 ((SUM_W'(fifo_count_i) + SUM_W'(inflight_q)) < SUM_W'(shrp_pkg::FIFO_DEPTH));
  assign is_last = ((rd_idx_q + 1'b1) == total_q);

  always_comb begin
    active_d   = active_q;
    rd_idx_d   = rd_idx_q;
    total_d    = total_q;
    depth_d    = depth_q;
    trunc_d    = trunc_q;
    inflight_d = issue;
    last_d     = last_q;
    if (start_i.valid) begin
      active_d = 1'b1;
      rd_idx_d = '0;
      total_d  = start_i.count;
      depth_d  = start_i.depth;
      trunc_d  = start_i.truncated;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
      last_d   = is_last;
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      rd_idx_q   <= '0;
      total_q    <= '0;
      depth_q    <= '0;
      trunc_q    <= 1'b0;
      inflight_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      active_q   <= active_d;
      rd_idx_q   <= rd_idx_d;
      total_q    <= total_d;
      depth_q    <= depth_d;
      trunc_q    <= trunc_d;
      inflight_q <= inflight_d;
      last_q     <= last_d;
    end
  end

  assign busy_o      = active_q | inflight_q;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_idx_q[shrp_pkg::IDX_W-1:0];

  assign push_o                = inflight_q;
  assign push_res_o.kind       = shrp_pkg::KIND_NEAR;
  assign push_res_o.name_value = ram_rdata_i;
  assign push_res_o.depth      = depth_q;
  assign push_res_o.truncated  = trunc_q;
  assign push_res_o.last       = last_q;

endmodule

// ===== rtl/shrp_out_fifo.sv =====
module shrp_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  shrp_pkg::res_t               push_res_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output shrp_pkg::res_t               res_o,
  output logic [shrp_pkg::FCNT_W-1:0]  count_o
);

  shrp_pkg::res_t              slot_q [shrp_pkg::FIFO_DEPTH];
  logic [shrp_pkg::FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [shrp_pkg::FCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o = (count_q != '0);
  assign res_o   = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/select_hit_record_parser.sv =====
// Selection buffer hit parser. Buffer words stream in on the slave side, one
// beat per word (tuser = 0), and are parsed as hit records: name count, min
// depth, max depth, then the names; only the first hit_count records of a
// pass count. In all mode (mode = 0) each name leaves as its own beat right
// away. In nearest mode (mode = 1) the names of the closest non-empty record
// (strictly smaller min depth, first record wins ties, all-ones depth never
// wins) are kept in a 16-entry name RAM; names beyond 16 are dropped and
// the truncated bit is raised. A finish beat (tuser = 1) ends the pass: in
// nearest mode it is followed by the stored names as a burst with tlast on
// the final one, or by one no-hit beat; in all mode it gives nothing.
// Rate: every buffer word takes one cycle, back to back, as long as the
// 4-beat output queue has room and no burst is being read out. A nearest-mode
// burst is read out of the name RAM one entry a cycle while the queue has
// room; each name passes the RAM read register into the output queue, and
// the slave side stays closed until the last name has entered the queue.
// Config writes are always taken and must only happen while no beat is in
// flight.
module select_hit_record_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [shrp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [shrp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [shrp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [31:0] word
  input  logic [shrp_pkg::IN_TUSER_W-1:0]       s_axis_tuser,  // [0] cmd
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] name_value, [63:32] depth, [64] truncated, [71:65] zero
  output logic [shrp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [shrp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,  // [1:0] kind
  output logic                                  m_axis_tlast
);

  shrp_pkg::cfg_wr_t            cfg;
  shrp_pkg::burst_start_t       burst_start;
  shrp_pkg::res_t               p_res, b_res, q_res, push_res;
  logic                         in_accept;
  logic                         p_push, b_push, push;
  logic                         burst_busy;
  logic                         ram_we, ram_re;
  logic [shrp_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [shrp_pkg::NAME_W-1:0]  ram_wdata, ram_rdata;
  logic [shrp_pkg::FCNT_W-1:0]  fifo_count;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = shrp_pkg::reg_e'(cfg_index_i);
  assign cfg.data    = cfg_data_i;

  // a word can push one beat at accept, so a full queue stalls the input
  assign s_axis_tready = !burst_busy &&
                         (fifo_count != shrp_pkg::FCNT_W'(shrp_pkg::FIFO_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  shrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .cmd_i       (s_axis_tuser[0]),
    .word_i      (s_axis_tdata[shrp_pkg::NAME_W-1:0]),
    .push_o      (p_push),
    .push_res_o  (p_res),
    .burst_o     (burst_start),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  shrp_name_ram #(
    .DEPTH (shrp_pkg::MAX_NAMES),
    .WIDTH (shrp_pkg::NAME_W),
    .AW    (shrp_pkg::IDX_W)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  shrp_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (burst_start),
    .fifo_count_i (fifo_count),
    .busy_o       (burst_busy),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .push_o       (b_push),
    .push_res_o   (b_res)
  );

  // parser pushes only on accepted beats, never while a burst is busy
  assign push     = p_push | b_push;
  assign push_res = b_push ? b_res : p_res;

  shrp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_res_i (push_res),
    .pop_i      (m_axis_tvalid && m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .res_o      (q_res),
    .count_o    (fifo_count)
  );

  assign m_axis_tdata = shrp_pkg::OUT_TDATA_W'({q_res.truncated, q_res.depth, q_res.name_value});
  assign m_axis_tuser = q_res.kind;
  assign m_axis_tlast = q_res.last;

endmodule

// ===== rtl/shrp_checker.sv =====
module shrp_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [shrp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic [shrp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  input  logic                                  m_axis_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // no-hit is a single closing beat with empty payload
  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == shrp_pkg::KIND_NONE) |->
    m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed no-hit beat");

  // all-mode names never close a burst nor carry truncation
  a_all_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == shrp_pkg::KIND_ALL) |->
    !m_axis_tlast && !m_axis_tdata[64])
    else $error("all-mode beat with last or truncated set");

  // kind code three is never produced
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined result kind");

endmodule

bind select_hit_record_parser shrp_checker u_shrp_checker (.*);

// ===== bench/shrp_hit_checker.sv =====
module shrp_hit_checker
  import shrp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [OUT_TUSER_W-1:0] m_tuser_i,
  input  logic                   m_tlast_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  // register copies
  logic [HIT_W-1:0]   hit_count_q;
  logic               mode_q;

  // parse state of the current pass
  pos_e               field_pos;
  logic [31:0]        names_left;
  logic [HIT_W-1:0]   records_done;
  logic [31:0]        cur_count;
  logic [DEPTH_W-1:0] cur_depth;
  logic               capture_on;
  logic [DEPTH_W-1:0] best_depth;
  logic               best_found;
  int unsigned        best_count;
  logic               best_trunc;
  logic [NAME_W-1:0]  best_names [MAX_NAMES];

  res_t               hits_due [$];
  int                 mismatch_cnt = 0;
  int                 pending_cnt  = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  task automatic clear_pass_state();
    field_pos    = POS_COUNT;
    names_left   = '0;
    records_done = '0;
    cur_count    = '0;
    cur_depth    = '0;
    capture_on   = 1'b0;
    best_depth   = '1;
    best_found   = 1'b0;
    best_count   = 0;
    best_trunc   = 1'b0;
    foreach (best_names[i]) best_names[i] = '0;
  endtask

  task automatic close_record();
    records_done = records_done + 1'b1;
    field_pos    = POS_COUNT;
    capture_on   = 1'b0;
  endtask

  // Work out the hits caused by one accepted input beat.
  task automatic parse_beat(input logic cmd, input logic [31:0] word);
    if (cmd) begin
      if (mode_q) begin
        if (best_found && best_count > 0) begin
          for (int i = 0; i < best_count; i++)
            hits_due.insert(hits_due.size(),
                            res_t'{KIND_NEAR, best_names[i], best_depth, best_trunc,
                                   (i + 1 == best_count)});
        end else begin
          hits_due.insert(hits_due.size(), res_t'{KIND_NONE, '0, '0, 1'b0, 1'b1});
        end
      end
      clear_pass_state();
    end else if (records_done < hit_count_q) begin
      case (field_pos)
        POS_COUNT: begin
          cur_count  = word;
          names_left = word;
          field_pos  = POS_MIN;
        end
        POS_MIN: begin
          cur_depth  = word;
          capture_on = 1'b0;
          if (mode_q && cur_count != 0 && word < best_depth) begin
            best_depth = word;
            best_found = 1'b1;
            best_count = 0;
            best_trunc = 1'b0;
            capture_on = 1'b1;
          end
          field_pos = POS_MAX;
        end
        POS_MAX: begin
          if (names_left == 0) close_record();
          else field_pos = POS_NAMES;
        end
        default: begin
          if (!mode_q) begin
            hits_due.insert(hits_due.size(), res_t'{KIND_ALL, word, cur_depth, 1'b0, 1'b0});
          end else if (capture_on) begin
            if (best_count < MAX_NAMES) begin
              best_names[best_count] = word;
              best_count++;
            end else begin
              best_trunc = 1'b1;
            end
          end
          names_left = names_left - 1;
          if (names_left == 0) close_record();
        end
      endcase
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_hit;
    if (!rst_ni) begin
      hit_count_q = '0;
      mode_q      = 1'b0;
      clear_pass_state();
      hits_due.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_HIT_COUNT: hit_count_q = cfg_data_i;
          REG_MODE:      mode_q      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) parse_beat(s_tuser_i[0], s_tdata_i[31:0]);
      if (m_tvalid_i && m_tready_i) begin
        if (hits_due.size() == 0) begin
          $display("%0t: no result expected, got kind %0d name %h depth %h trunc %0b last %0b",
                   $time, m_tuser_i, m_tdata_i[31:0], m_tdata_i[63:32], m_tdata_i[64],
                   m_tlast_i);
          mismatch_cnt++;
        end else begin
          exp_hit = hits_due.pop_front();
          check_field("kind",      32'(exp_hit.kind),       32'(m_tuser_i));
          check_field("name",      exp_hit.name_value,      m_tdata_i[31:0]);
          check_field("depth",     exp_hit.depth,           m_tdata_i[63:32]);
          check_field("truncated", 32'(exp_hit.truncated),  32'(m_tdata_i[64]));
          check_field("last",      32'(exp_hit.last),       32'(m_tlast_i));
          check_field("tdata pad", 32'd0,                   32'(m_tdata_i[71:65]));
        end
      end
      pending_cnt = hits_due.size();
    end
  end

endmodule

// ===== bench/tb_select_hit_record_parser.sv =====
module tb_select_hit_record_parser;
  import shrp_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] word
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] name, [63:32] depth, [64] trunc, pad
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // [1:0] kind
  logic                   m_axis_tlast;

  int   mismatches;
  int   hits_pending;
  bit   idle_on;      // random gaps on both sides while set
  int   beats_sent;   // accepted input beats, for sizing the run
  logic cur_mode;     // last mode written, so a mid-pass flip knows where to go

  select_hit_record_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checker sits beside the block, watching all three channels.
  shrp_hit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (hits_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (16-name bursts with full
  // receiver stalls, sender gaps and a drain wait after every pass).
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts while idle_on is set.
  // Only one NBA to tready per edge.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // One input beat. A gap, if any, drops tvalid first; otherwise tvalid
  // stays high straight into the next beat.
  task automatic send_beat(input logic cmd, input logic [31:0] word);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Stop sending, wait for every predicted hit, then give a burst readout
  // time to finish even when the last words caused nothing.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (hits_pending != 0);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Config only ever changes with the block idle.
  task automatic setup_pass(input logic [HIT_W-1:0] hits, input logic md);
    drain();
    cfg_write(REG_HIT_COUNT, hits);
    cfg_write(REG_MODE, CFG_DATA_W'(md));
    cur_mode = md;
  endtask

  // Directed pass: fixed words, then a finish beat with a random word.
  task automatic feed_pass(input logic [HIT_W-1:0] hits, input logic md,
                           input logic [31:0] words [$]);
    setup_pass(hits, md);
    foreach (words[i]) send_beat(1'b0, words[i]);
    send_beat(1'b1, $urandom);
  endtask

  // Random pass: mostly well-formed records with random content, plus
  // finishes cut into records, mid-pass mode flips, words past the last
  // record, empty records, overlong records and runaway name counts.
  task automatic random_pass();
    logic [HIT_W-1:0] hits;
    logic [31:0]      rec [$];
    logic [31:0]      count;
    logic [31:0]      depth;
    int               n_rec;
    int               n_names;
    int               cut_at;
    int               flip_at;
    int               pick;
    bit               ended;
    pick = $urandom_range(0, 7);
    hits = (pick == 0) ? '0 : (pick == 1) ? '1 : HIT_W'($urandom_range(1, 6));
    setup_pass(hits, 1'($urandom_range(0, 1)));
    n_rec = (hits == 0 || hits == '1) ? $urandom_range(1, 4) : hits;
    ended = 1'b0;
    for (int k = 0; k < n_rec && !ended; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2)       count = 0;
      else if (pick < 5)  count = $urandom_range(15, 18);   // around the name store size
      else if (pick == 5) count = $urandom | 32'h100;        // never completes
      else                count = $urandom_range(1, 4);
      pick = $urandom_range(0, 9);
      // small depths make ties likely; all ones must never win
      if (pick < 5)       depth = $urandom_range(0, 7);
      else if (pick == 5) depth = '1;
      else                depth = $urandom;
      rec = {count, depth, $urandom};
      n_names = (count > 18) ? $urandom_range(1, 5) : int'(count);
      repeat (n_names) rec = {rec, $urandom};
      cut_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rec.size() - 1)
                                            : rec.size();
      flip_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rec.size() - 1) : -1;
      for (int i = 0; i < cut_at; i++) begin
        if (i == flip_at) begin
          drain();
          cfg_write(REG_MODE, CFG_DATA_W'(!cur_mode));
          cur_mode = !cur_mode;
        end
        send_beat(1'b0, rec[i]);
      end
      if (cut_at < rec.size() || count > 18) ended = 1'b1;
    end
    // words after the last counted record are dropped by the parser
    if (!ended && hits != 0 && hits != '1)
      repeat ($urandom_range(0, 2)) send_beat(1'b0, $urandom);
    send_beat(1'b1, $urandom);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_HIT_COUNT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    idle_on    = 1'b0;
    beats_sent = 0;
    cur_mode   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    // all mode: empty record, then extreme words, a word past the last
    // record, and a finish that must stay silent
    feed_pass(16'd2, 1'b0, {32'd0, 32'd1, 32'd2,
                            32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF,
                            32'h1234_5678});
    // nearest: an all-ones min depth never wins, so no hit
    feed_pass(16'd1, 1'b1, {32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0});
    // nearest: tie on depth 7, the first record keeps its two names
    feed_pass(16'd3, 1'b1, {32'd2, 32'd7, 32'd8, 32'hA5A5_0001, 32'h5A5A_0002,
                            32'd1, 32'd7, 32'd7, 32'hC0DE_0003});
    // nearest: finish before any name of the best record arrived
    feed_pass(16'd1, 1'b1, {32'd1, 32'd4, 32'd4});

    while (beats_sent < 160) begin
      // the tail of the run goes without any idling
      idle_on = (beats_sent < 125) ? ($urandom_range(0, 3) != 0) : 1'b0;
      random_pass();
    end
    drain();

    if (mismatches == 0 && hits_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/shrp_pkg.sv
rtl/shrp_name_ram.sv
rtl/shrp_parser.sv
rtl/shrp_burst.sv
rtl/shrp_out_fifo.sv
rtl/select_hit_record_parser.sv
rtl/shrp_checker.sv
bench/shrp_hit_checker.sv
bench/tb_select_hit_record_parser.sv
